[src/tcw_pkg.sv]
// Package for the text console writer: field widths, request and character
// codes, reset attribute and the cell type.
// No dependencies; imported by text_console_writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // Port field widths
    localparam int REQ_W        = 2;
    localparam int CHAR_W       = 8;
    localparam int ATTR_W       = 8;
    localparam int CELL_W       = 16;
    localparam int CELL_INDEX_W = 11;
    localparam int CUR_COL_W    = 7;
    localparam int CUR_ROW_W    = 5;
    localparam int CUR_POS_W    = 11;

    typedef logic [REQ_W-1:0]        req_t;
    typedef logic [CHAR_W-1:0]       char_t;
    typedef logic [ATTR_W-1:0]       attr_t;
    typedef logic [CELL_W-1:0]       cell_t;
    typedef logic [CELL_INDEX_W-1:0] cell_index_t;

    // Request codes
    localparam req_t REQ_PUT   = 2'd0;
    localparam req_t REQ_READ  = 2'd1;
    localparam req_t REQ_CLEAR = 2'd2;

    // Character codes and constants
    localparam char_t CHAR_NEWLINE = 8'd10;
    localparam char_t CHAR_TAB     = 8'd9;
    localparam char_t BLANK_CHAR   = 8'd32;
    localparam attr_t ATTR_RESET   = 8'd138;
    localparam int    TAB_STEP     = 4;

endpackage

`default_nettype wire

[src/tcw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the screen cells of text_console_writer.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, hold when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[src/text_console_writer.sv]
// Text console writer top level: cursor control, sequencer and result register.
// Depends on tcw_pkg and tcw_ram (screen cell store).
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     req_type, char_code, cell_index
//   out      output     out_valid / out_stall   cursor_col, cursor_row, cursor_pos,
//                                               cell_data, scrolled
//   cfg      input      cfg_valid / cfg_ready   text_attr
//
// Put character, read cell and unused requests go from accept to the result step.
// Clear blanks every cell first; a put that scrolls copies rows up, then blanks
// the bottom row. CELLS = ROWS * COLUMNS; the single port pair of the cell store
// moves one cell per cycle during scroll and blanking. After reset a clearing pass
// over all CELLS cells runs before the first transaction.
// A stalled result is held in the output register; the next transaction is
// accepted once the engine is back in idle.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Request channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire tcw_pkg::req_t        req_type,
    input  wire tcw_pkg::char_t       char_code,
    input  wire tcw_pkg::cell_index_t cell_index,
    // Result channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [6:0]                cursor_col,
    output logic [4:0]                cursor_row,
    output logic [10:0]               cursor_pos,
    output tcw_pkg::cell_t            cell_data,
    output logic                      scrolled,
    // Attribute register write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire tcw_pkg::attr_t       text_attr
);

    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW  = $clog2(CELL_COUNT);
    localparam int PW  = $clog2(CELL_COUNT + 1);
    localparam int CW  = $clog2(COLUMNS);
    localparam int CUW = $clog2(COLUMNS + TAB_STEP);
    localparam int RW  = $clog2(ROWS);

    localparam logic [PW-1:0]  LAST_CELL      = PW'(CELL_COUNT - 1);
    localparam logic [PW-1:0]  LAST_ROW_START = PW'(CELL_COUNT - COLUMNS);
    localparam logic [PW-1:0]  COLS_P         = PW'(COLUMNS);
    localparam logic [CUW-1:0] COLS_U         = CUW'(COLUMNS);
    localparam logic [RW-1:0]  LAST_ROW       = RW'(ROWS - 1);

    // Sequencer states
    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCROLL = 3'd2;
    localparam logic [2:0] S_BLANK  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [PW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [PW-1:0] pos_reg, pos_next;
    attr_t         attr_reg;
    logic          scroll_reg, scroll_next;
    logic          rd_ok_reg, rd_ok_next;
    logic          out_valid_reg;

    logic          in_acc;
    logic          load_out;
    logic          line_brk;
    logic [CUW-1:0] col_u;
    logic [PW-1:0] row_base;
    attr_t         blank_attr;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    cell_t         ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    cell_t         ram_rdata;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign row_base  = pos_reg - PW'(col_reg);
    assign blank_attr = (state_reg == S_INIT) ? ATTR_RESET : attr_reg;

    // Screen cell store
    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer and cursor update
    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        pos_next    = pos_reg;
        scroll_next = scroll_reg;
        rd_ok_next  = rd_ok_reg;
        load_out    = 1'b0;
        line_brk    = 1'b0;
        col_u       = CUW'(col_reg);
        ram_we      = 1'b0;
        ram_waddr   = AW'(ptr_reg);
        ram_wdata   = {blank_attr, BLANK_CHAR};
        ram_re      = 1'b0;
        ram_raddr   = AW'(cell_index);

        unique case (state_reg)
            S_INIT:
            begin
                ram_we = 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + PW'(1);
                end
            end

            S_IDLE:
            begin
                if (in_acc)
                begin
                    scroll_next = 1'b0;
                    rd_ok_next  = 1'b0;
                    state_next  = S_FINISH;
                    case (req_type)
                        REQ_PUT:
                        begin
                            // Move or store, then wrap and scroll
                            if (char_code == CHAR_NEWLINE)
                            begin
                                line_brk = 1'b1;
                            end
                            else if (char_code == CHAR_TAB)
                            begin
                                col_u = CUW'(col_reg) + CUW'(TAB_STEP);
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(pos_reg);
                                ram_wdata = {attr_reg, char_code};
                                col_u     = CUW'(col_reg) + CUW'(1);
                            end
                            if (!line_brk && (col_u < COLS_U))
                            begin
                                col_next = CW'(col_u);
                                pos_next = row_base + PW'(col_u);
                            end
                            else
                            begin
                                col_next = '0;
                                if (row_reg == LAST_ROW)
                                begin
                                    scroll_next = 1'b1;
                                    pos_next    = LAST_ROW_START;
                                    ptr_next    = '0;
                                    state_next  = S_SCROLL;
                                end
                                else
                                begin
                                    row_next = row_reg + RW'(1);
                                    pos_next = row_base + COLS_P;
                                end
                            end
                        end
                        REQ_READ:
                        begin
                            ram_re     = 1'b1;
                            rd_ok_next = (32'(cell_index) < CELL_COUNT);
                        end
                        REQ_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            pos_next   = '0;
                            ptr_next   = '0;
                            state_next = S_BLANK;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_SCROLL:
            begin
                // Read one row ahead, write the previous read back in the following cycle
                ram_re    = (ptr_reg < LAST_ROW_START);
                ram_raddr = AW'(ptr_reg + COLS_P);
                ram_we    = (ptr_reg != '0);
                ram_waddr = AW'(ptr_reg - PW'(1));
                ram_wdata = ram_rdata;
                if (ptr_reg == LAST_ROW_START)
                begin
                    state_next = S_BLANK;
                end
                else
                begin
                    ptr_next = ptr_reg + PW'(1);
                end
            end

            S_BLANK:
            begin
                ram_we = 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    ptr_next   = '0;
                    state_next = S_FINISH;
                end
                else
                begin
                    ptr_next = ptr_reg + PW'(1);
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            ptr_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            pos_reg       <= '0;
            scroll_reg    <= 1'b0;
            rd_ok_reg     <= 1'b0;
            attr_reg      <= ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            pos_reg    <= pos_next;
            scroll_reg <= scroll_next;
            rd_ok_reg  <= rd_ok_next;
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= text_attr;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, loaded when the transaction finishes
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            cursor_col <= CUR_COL_W'(col_reg);
            cursor_row <= CUR_ROW_W'(row_reg);
            cursor_pos <= CUR_POS_W'(pos_reg);
            cell_data  <= rd_ok_reg ? ram_rdata : '0;
            scrolled   <= scroll_reg;
        end
    end

`ifndef ASSERT_OFF
    // Linear cursor position tracks row and column
    a_pos_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg == PW'(32'(row_reg) * COLUMNS + 32'(col_reg)))
        else $error("cursor position out of step with row and column");

    // Cursor stays on the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(col_reg) < COLUMNS) && (32'(row_reg) < ROWS))
        else $error("cursor off screen");

    // A result only appears after the engine finishes a transaction
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FINISH)
        else $error("result without finished transaction");

    // Only a put writes the store while idle
    a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg == S_IDLE) |-> (in_acc && req_type == REQ_PUT))
        else $error("unexpected cell write in idle");
`endif

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking bench for text_console_writer: directed table, then random phases.
// Depends on tcw_pkg and the text_console_writer RTL; holds its own screen predictor.
`timescale 1ns / 1ps

module tb_top;

    import tcw_pkg::*;

    localparam int NUM_COLS       = 80;
    localparam int NUM_ROWS       = 25;
    localparam int CELL_COUNT     = NUM_COLS * NUM_ROWS;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 145;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PROBE_ROWS     = 24;
    localparam req_t REQ_UNUSED   = 2'd3;

    typedef struct packed {
        logic [6:0]  col;
        logic [4:0]  row;
        logic [10:0] pos;
        cell_t       data;
        logic        scrolled;
    } console_result_t;

    typedef struct packed {
        req_t        req;
        char_t       ch;
        cell_index_t idx;
        logic [4:0]  reps;
        logic        typed;
        logic [6:0]  e_col;
        logic [4:0]  e_row;
        cell_t       e_data;
        logic        e_scr;
    } probe_row_t;

    // Directed rows; typed expectations only where they are obvious
    probe_row_t probe_table [0:PROBE_ROWS-1] = '{
        '{REQ_READ,   8'h00,        11'd0,    5'd1,  1'b1, 7'd0, 5'd0,  16'h8A20, 1'b0},
        '{REQ_READ,   8'h00,        11'd1999, 5'd1,  1'b1, 7'd0, 5'd0,  16'h8A20, 1'b0},
        '{REQ_READ,   8'h00,        11'd2047, 5'd1,  1'b1, 7'd0, 5'd0,  16'h0000, 1'b0},
        '{REQ_UNUSED, 8'hFF,        11'd2047, 5'd1,  1'b1, 7'd0, 5'd0,  16'h0000, 1'b0},
        '{REQ_PUT,    8'h00,        11'd2047, 5'd1,  1'b1, 7'd1, 5'd0,  16'h0000, 1'b0},
        '{REQ_PUT,    8'hFF,        11'd0,    5'd1,  1'b1, 7'd2, 5'd0,  16'h0000, 1'b0},
        '{REQ_READ,   8'h00,        11'd0,    5'd1,  1'b1, 7'd2, 5'd0,  16'h8A00, 1'b0},
        '{REQ_READ,   8'h00,        11'd1,    5'd1,  1'b1, 7'd2, 5'd0,  16'h8AFF, 1'b0},
        '{REQ_PUT,    CHAR_TAB,     11'd0,    5'd1,  1'b1, 7'd6, 5'd0,  16'h0000, 1'b0},
        '{REQ_PUT,    CHAR_NEWLINE, 11'd0,    5'd1,  1'b1, 7'd0, 5'd1,  16'h0000, 1'b0},
        '{REQ_PUT,    CHAR_TAB,     11'd0,    5'd19, 1'b0, 7'd0, 5'd0,  16'h0000, 1'b0},
        '{REQ_PUT,    8'h41,        11'd0,    5'd3,  1'b0, 7'd0, 5'd0,  16'h0000, 1'b0},
        '{REQ_PUT,    8'h42,        11'd0,    5'd1,  1'b1, 7'd0, 5'd2,  16'h0000, 1'b0},
        '{REQ_READ,   8'h00,        11'd159,  5'd1,  1'b1, 7'd0, 5'd2,  16'h8A42, 1'b0},
        '{REQ_PUT,    CHAR_TAB,     11'd0,    5'd19, 1'b0, 7'd0, 5'd0,  16'h0000, 1'b0},
        '{REQ_PUT,    8'h43,        11'd0,    5'd1,  1'b0, 7'd0, 5'd0,  16'h0000, 1'b0},
        '{REQ_PUT,    CHAR_TAB,     11'd0,    5'd1,  1'b1, 7'd0, 5'd3,  16'h0000, 1'b0},
        '{REQ_PUT,    CHAR_NEWLINE, 11'd0,    5'd20, 1'b0, 7'd0, 5'd0,  16'h0000, 1'b0},
        '{REQ_PUT,    CHAR_NEWLINE, 11'd0,    5'd1,  1'b1, 7'd0, 5'd24, 16'h0000, 1'b0},
        '{REQ_PUT,    CHAR_NEWLINE, 11'd0,    5'd1,  1'b1, 7'd0, 5'd24, 16'h0000, 1'b1},
        '{REQ_READ,   8'h00,        11'd76,   5'd1,  1'b1, 7'd0, 5'd24, 16'h8A41, 1'b0},
        '{REQ_READ,   8'h00,        11'd1999, 5'd1,  1'b1, 7'd0, 5'd24, 16'h8A20, 1'b0},
        '{REQ_CLEAR,  8'h00,        11'd0,    5'd1,  1'b1, 7'd0, 5'd0,  16'h0000, 1'b0},
        '{REQ_READ,   8'h00,        11'd79,   5'd1,  1'b1, 7'd0, 5'd0,  16'h8A20, 1'b0}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    req_t        req_type;
    char_t       char_code;
    cell_index_t cell_index;
    logic        out_valid;
    logic        out_stall;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_pos;
    cell_t       cell_data;
    logic        scrolled;
    logic        cfg_valid;
    logic        cfg_ready;
    attr_t       text_attr;

    // Predictor state
    cell_t           screen_model [0:CELL_COUNT-1];
    int              col_model;
    int              row_model;
    attr_t           attr_model;
    console_result_t expected_results [$];

    bit              typed_now;
    console_result_t typed_result;
    bit              gaps_on;
    int              error_count;
    int              quiet_cycles;

    text_console_writer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .char_code  (char_code),
        .cell_index (cell_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .cursor_pos (cursor_pos),
        .cell_data  (cell_data),
        .scrolled   (scrolled),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .text_attr  (text_attr)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Apply one request to the screen predictor and return the result it yields
    function automatic console_result_t predict_console(req_t r, char_t c, cell_index_t i);
        console_result_t res;
        int              at;
        int              k;
        res = '0;
        case (r)
            REQ_PUT:
            begin
                if (c == CHAR_NEWLINE)
                begin
                    col_model = 0;
                    row_model++;
                end
                else if (c == CHAR_TAB)
                    col_model += TAB_STEP;
                else
                begin
                    at = row_model * NUM_COLS + col_model;
                    if (at < CELL_COUNT)
                        screen_model[at] = {attr_model, c};
                    col_model++;
                end
                // wrap at or past the last column
                if (col_model >= NUM_COLS)
                begin
                    col_model = 0;
                    row_model++;
                end
                // scroll up one row and blank the bottom row
                if (row_model >= NUM_ROWS)
                begin
                    for (k = 0; k < CELL_COUNT - NUM_COLS; k++)
                        screen_model[k] = screen_model[k + NUM_COLS];
                    for (k = CELL_COUNT - NUM_COLS; k < CELL_COUNT; k++)
                        screen_model[k] = {attr_model, BLANK_CHAR};
                    row_model = NUM_ROWS - 1;
                    res.scrolled = 1'b1;
                end
            end
            REQ_READ:
            begin
                if (i < CELL_COUNT)
                    res.data = screen_model[i];
            end
            REQ_CLEAR:
            begin
                for (k = 0; k < CELL_COUNT; k++)
                    screen_model[k] = {attr_model, BLANK_CHAR};
                col_model = 0;
                row_model = 0;
            end
            default: ;
        endcase
        res.col = col_model[6:0];
        res.row = row_model[4:0];
        res.pos = 11'(row_model * NUM_COLS + col_model);
        return res;
    endfunction

    // Drive one request transaction and hold it until accepted
    task automatic send_request(req_t r, char_t c, cell_index_t i, bit tp,
                                console_result_t want);
        int gap;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 15);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        req_type     <= r;
        char_code    <= c;
        cell_index   <= i;
        typed_now    = tp;
        typed_result = want;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    // Stall the result channel in random bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (gaps_on && $urandom_range(0, 6) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Check results, record accepted requests and register writes, watch for hangs
    always @(posedge clk)
    begin
        console_result_t want;
        console_result_t got;
        bit              moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result col %0d row %0d data %h", $time,
                             cursor_col, cursor_row, cell_data);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (cursor_col !== want.col)
                    begin
                        error_count++;
                        $display("%0t: cursor_col expected %0d actual %0d", $time,
                                 want.col, cursor_col);
                    end
                    if (cursor_row !== want.row)
                    begin
                        error_count++;
                        $display("%0t: cursor_row expected %0d actual %0d", $time,
                                 want.row, cursor_row);
                    end
                    if (cursor_pos !== want.pos)
                    begin
                        error_count++;
                        $display("%0t: cursor_pos expected %0d actual %0d", $time,
                                 want.pos, cursor_pos);
                    end
                    if (cell_data !== want.data)
                    begin
                        error_count++;
                        $display("%0t: cell_data expected %h actual %h", $time,
                                 want.data, cell_data);
                    end
                    if (scrolled !== want.scrolled)
                    begin
                        error_count++;
                        $display("%0t: scrolled expected %0d actual %0d", $time,
                                 want.scrolled, scrolled);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                got = predict_console(req_type, char_code, cell_index);
                expected_results.push_back(typed_now ? typed_result : got);
            end
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                attr_model = text_attr;
            end
            if (moved)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Stimulus: directed table, then random phases separated by attribute writes
    initial
    begin
        int              k;
        int              m;
        int              phase;
        int              n;
        int              pick;
        int              sub;
        int              near;
        req_t            r;
        char_t           c;
        cell_index_t     i;
        console_result_t want;
        probe_row_t      pr;
        attr_t           next_attr;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        req_type     = REQ_PUT;
        char_code    = '0;
        cell_index   = '0;
        cfg_valid    = 1'b0;
        text_attr    = '0;
        typed_now    = 1'b0;
        typed_result = '0;
        gaps_on      = 1'b1;
        error_count  = 0;
        quiet_cycles = 0;
        col_model    = 0;
        row_model    = 0;
        attr_model   = ATTR_RESET;
        for (k = 0; k < CELL_COUNT; k++)
            screen_model[k] = {ATTR_RESET, BLANK_CHAR};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        for (k = 0; k < PROBE_ROWS; k++)
        begin
            pr = probe_table[k];
            want.col      = pr.e_col;
            want.row      = pr.e_row;
            want.pos      = 11'(pr.e_row * NUM_COLS + pr.e_col);
            want.data     = pr.e_data;
            want.scrolled = pr.e_scr;
            for (m = 0; m < pr.reps; m++)
                send_request(pr.req, pr.ch, pr.idx, pr.typed, want);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            // Drain, then rewrite the attribute while idle
            @(negedge clk);
            in_valid <= 1'b0;
            while (expected_results.size() != 0)
                @(posedge clk);
            case (phase)
                0:       next_attr = 8'h00;
                1:       next_attr = 8'hFF;
                default: next_attr = attr_t'($urandom_range(0, 255));
            endcase
            @(negedge clk);
            cfg_valid <= 1'b1;
            text_attr <= next_attr;
            do
                @(posedge clk);
            while (cfg_ready !== 1'b1);
            @(negedge clk);
            cfg_valid <= 1'b0;

            // Random requests: mostly text with newlines and tabs, plus reads, unused codes and clears
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == PHASES - 1)
                    gaps_on = 1'b0;
                else if (n % 40 == 0)
                    gaps_on = ($urandom_range(0, 3) != 0);
                pick = $urandom_range(0, 99);
                sub  = $urandom_range(0, 19);
                c    = char_t'($urandom_range(0, 255));
                i    = cell_index_t'($urandom_range(0, 2047));
                if (pick < 55)
                begin
                    r = REQ_PUT;
                    if (sub < 2)
                        c = CHAR_NEWLINE;
                    else if (sub < 4)
                        c = CHAR_TAB;
                end
                else if (pick < 94)
                begin
                    r = REQ_READ;
                    if (sub < 12)
                    begin
                        near = row_model * NUM_COLS + col_model - $urandom_range(0, 40);
                        i = cell_index_t'(near < 0 ? 0 : near);
                    end
                    else if (sub < 18)
                        i = cell_index_t'($urandom_range(0, CELL_COUNT - 1));
                    else
                        i = cell_index_t'($urandom_range(CELL_COUNT, 2047));
                end
                else if (pick < 99)
                    r = REQ_UNUSED;
                else
                    r = REQ_CLEAR;
                send_request(r, c, i, 1'b0, '0);
            end
        end

        // Wait out the last results, then a short tail for strays
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
